// ===== hw/rtl/tps_pkg.sv =====
// Shared constants for the tridiagonal Poisson solver.
// Holds the Q8.24 number format, store sizes and divider widths; no dependencies.
package tps_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);
  localparam int unsigned IndexW    = 6;

  // Signed Q8.24 samples.
  localparam int unsigned QW    = 32;
  localparam int unsigned FracW = 24;

  localparam logic signed [QW-1:0] QOne = QW'(32'sd16777216);
  localparam logic signed [QW-1:0] QTwo = QW'(32'sd33554432);
  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};

  // Divider: magnitude of the dividend scaled by 2^FracW.
  localparam int unsigned DvdW    = QW + FracW;
  localparam int unsigned DivCntW = $clog2(DvdW);

endpackage

// ===== hw/rtl/tps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependencies.
module tps_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tps_div.sv =====
// Iterative Q8.24 divider, one quotient bit per cycle, saturating result.
// Depends on tps_pkg for the number format and widths.
module tps_div import tps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [QW-1:0] num_i,
  input  logic signed [QW-1:0] den_i,
  output logic                 done_o,
  output logic signed [QW-1:0] quot_o
);

  typedef enum logic [2:0] {
    DivIdle = 3'b001,
    DivRun  = 3'b010,
    DivFin  = 3'b100
  } div_state_e;

  div_state_e           state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DvdW-1:0]      dvd_q;
  logic [QW-1:0]        rem_q;
  logic [QW-1:0]        mag_den_q;
  logic                 neg_q, num_neg_q, zero_q;
  logic signed [QW-1:0] quot_q;

  logic [QW:0]          shifted;
  logic                 ge;
  logic [QW:0]          diff;
  logic [QW-1:0]        abs_num, abs_den;
  logic signed [QW-1:0] result;

  assign abs_num = num_i[QW-1] ? QW'(-num_i) : QW'(num_i);
  assign abs_den = den_i[QW-1] ? QW'(-den_i) : QW'(den_i);

  // Restoring step: shift in the next dividend bit and subtract if it fits.
  assign shifted = {rem_q, dvd_q[DvdW-1]};
  assign ge      = shifted >= {1'b0, mag_den_q};
  assign diff    = shifted - {1'b0, mag_den_q};

  // Sign and saturation of the finished quotient held in dvd_q.
  always_comb begin
    if (zero_q) begin
      result = num_neg_q ? QMin : QMax;
    end else if (neg_q) begin
      if ((|dvd_q[DvdW-1:QW]) || (dvd_q[QW-1] && (|dvd_q[QW-2:0]))) begin
        result = QMin;
      end else begin
        result = QW'(-dvd_q[QW-1:0]);
      end
    end else begin
      if (|dvd_q[DvdW-1:QW-1]) begin
        result = QMax;
      end else begin
        result = QW'(dvd_q[QW-1:0]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      DivIdle: begin
        if (start_i) begin
          state_d = DivRun;
          cnt_d   = DivCntW'(DvdW - 1);
        end
      end
      DivRun: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = DivFin;
        end
      end
      DivFin: begin
        state_d = DivIdle;
        done_d  = 1'b1;
      end
      default: begin
        state_d = DivIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DivIdle && start_i) begin
      dvd_q     <= {abs_num, {FracW{1'b0}}};
      rem_q     <= '0;
      mag_den_q <= abs_den;
      neg_q     <= num_i[QW-1] ^ den_i[QW-1];
      num_neg_q <= num_i[QW-1];
      zero_q    <= (den_i == '0);
    end else if (state_q == DivRun) begin
      rem_q <= ge ? diff[QW-1:0] : shifted[QW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], ge};
    end
    if (state_q == DivFin) begin
      quot_q <= result;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/tridiagonal_poisson_solver.sv =====
// Top level of the tridiagonal Poisson solver (Thomas algorithm, A = tridiag(-1, 2, -1)).
// Depends on tps_pkg, tps_ram (sample/solution and pivot stores) and tps_div.
// The input channel (in_valid_i / in_stall_o) takes one right-hand-side sample per request,
// signed Q8.24 and already scaled by the step squared, one request per cycle while loading.
// A request with final_point_i set, or the MaxPoints-th request of a run, closes the run
// and starts the solve. The output channel (out_valid_o / out_stall_i) then delivers one
// request per solution point, in index order, with last_result_o set on the final point.
// Every division runs on one shared bit-serial divider (start, the quotient bits one at a
// time, then sign and saturation). The forward sweep spends two divisions per point after
// the first, back substitution one division per point, and readout passes through
// StEmitRd and StEmitWr for each point. No request is taken from the close of a run until
// its last result sits in the output register.
// Reset empties the run and the output register; the stores need no clearing because a
// solve only reads entries written in the same run. A stalled result holds in the output
// register and readout waits; the next run may load while the last result of the
// previous run still waits to be taken.
module tridiagonal_poisson_solver import tps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [QW-1:0]     rhs_sample_i,
  input  logic                     final_point_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IndexW-1:0]        point_index_o,
  output logic signed [QW-1:0]     solution_value_o,
  output logic                     last_result_o
);

  // One-hot sequencer: load, forward sweep, back substitution, readout.
  typedef enum logic [8:0] {
    StLoad   = 9'b000000001,
    StFwdRd  = 9'b000000010,
    StFwdRcp = 9'b000000100,
    StFwdCar = 9'b000001000,
    StBwdGo  = 9'b000010000,
    StBwdDiv = 9'b000100000,
    StBwdRd  = 9'b001000000,
    StEmitRd = 9'b010000000,
    StEmitWr = 9'b100000000
  } tps_state_e;

  // Saturating Q8.24 add and subtract.
  function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? QMin : QMax;
    end
    return s[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? QMin : QMax;
    end
    return s[QW-1:0];
  endfunction

  tps_state_e           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;      // points loaded in this run
  logic [AddrW-1:0]     idx_q, idx_d;      // point under work
  logic                 out_valid_q, out_valid_d;

  // Carried pivot values: b' and g' of the previous point, or the divider operands
  // during back substitution.
  logic signed [QW-1:0] prev_b_q, prev_g_q;
  logic signed [QW-1:0] recip_q;
  logic signed [QW-1:0] next_solution_q;
  logic [IndexW-1:0]    point_index_q;
  logic signed [QW-1:0] solution_q;
  logic                 last_q;

  logic                 in_accept;
  logic                 out_take;
  logic [CntW-1:0]      cnt_inc, cnt_dec;
  logic [AddrW-1:0]     last_idx;
  logic                 run_done;
  logic                 out_free;

  // Sample / solution store. Samples are overwritten by solutions during back
  // substitution, once the forward sweep no longer needs them.
  logic                 a_we, a_re;
  logic [AddrW-1:0]     a_waddr, a_raddr;
  logic [QW-1:0]        a_wdata, a_rdata;

  // Pivot store, {b', g'} per point.
  logic                 p_we, p_re;
  logic [AddrW-1:0]     p_waddr, p_raddr;
  logic [2*QW-1:0]      p_wdata, p_rdata;

  logic                 div_start, div_done;
  logic signed [QW-1:0] div_num, div_quot;
  logic signed [QW-1:0] b_new, g_new;

  assign in_stall_o = (state_q != StLoad);
  assign in_accept  = in_valid_i && (state_q == StLoad);
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || out_take;

  assign cnt_inc  = cnt_q + 1'b1;
  assign cnt_dec  = cnt_q - 1'b1;
  assign last_idx = cnt_dec[AddrW-1:0];
  assign run_done = final_point_i || (cnt_inc == CntW'(MaxPoints));

  // Forward-sweep update for the current point.
  assign b_new = sat_sub(QTwo, recip_q);
  assign g_new = sat_add(signed'(a_rdata), div_quot);

  // The divider always divides by the carried b'; only the dividend changes.
  assign div_num   = (state_q == StFwdRd) ? QOne : prev_g_q;
  assign div_start = (state_q == StFwdRd) || (state_q == StBwdGo) ||
                     ((state_q == StFwdRcp) && div_done);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;

    a_we    = 1'b0;
    a_waddr = idx_q;
    a_wdata = div_quot;
    a_re    = 1'b0;
    a_raddr = idx_q;
    p_we    = 1'b0;
    p_waddr = idx_q;
    p_wdata = {b_new, g_new};
    p_re    = 1'b0;
    p_raddr = idx_q - 1'b1;

    case (state_q)
      StLoad: begin
        if (in_accept) begin
          a_we    = 1'b1;
          a_waddr = cnt_q[AddrW-1:0];
          a_wdata = rhs_sample_i;
          // The first point's pivot is fixed: b' = 2, g' = its sample.
          if (cnt_q == '0) begin
            p_we    = 1'b1;
            p_waddr = '0;
            p_wdata = {QTwo, rhs_sample_i};
          end
          cnt_d = cnt_inc;
          if (run_done) begin
            if (cnt_q == '0) begin
              idx_d   = '0;
              state_d = StBwdGo;
            end else begin
              idx_d   = AddrW'(1);
              state_d = StFwdRd;
            end
          end
        end
      end
      StFwdRd: begin
        a_re    = 1'b1;
        state_d = StFwdRcp;
      end
      StFwdRcp: begin
        if (div_done) begin
          state_d = StFwdCar;
        end
      end
      StFwdCar: begin
        if (div_done) begin
          p_we = 1'b1;
          if (idx_q == last_idx) begin
            state_d = StBwdGo;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StFwdRd;
          end
        end
      end
      StBwdGo: begin
        state_d = StBwdDiv;
      end
      StBwdDiv: begin
        if (div_done) begin
          a_we = 1'b1;
          if (idx_q == '0) begin
            state_d = StEmitRd;
          end else begin
            p_re    = 1'b1;
            idx_d   = idx_q - 1'b1;
            state_d = StBwdRd;
          end
        end
      end
      StBwdRd: begin
        state_d = StBwdGo;
      end
      StEmitRd: begin
        if (out_free) begin
          a_re    = 1'b1;
          state_d = StEmitWr;
        end
      end
      StEmitWr: begin
        out_valid_d = 1'b1;
        if (idx_q == last_idx) begin
          cnt_d   = '0;
          idx_d   = '0;
          state_d = StLoad;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StEmitRd;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && cnt_q == '0) begin
      prev_b_q <= QTwo;
      prev_g_q <= rhs_sample_i;
    end
    if (state_q == StFwdRcp && div_done) begin
      recip_q <= div_quot;
    end
    if (state_q == StFwdCar && div_done) begin
      prev_b_q <= b_new;
      prev_g_q <= g_new;
    end
    if (state_q == StBwdDiv && div_done) begin
      next_solution_q <= div_quot;
    end
    // Back substitution: the next dividend is g'(i-1) + v(i), the divisor b'(i-1).
    if (state_q == StBwdRd) begin
      prev_b_q <= signed'(p_rdata[2*QW-1:QW]);
      prev_g_q <= sat_add(signed'(p_rdata[QW-1:0]), next_solution_q);
    end
    if (state_q == StEmitWr) begin
      point_index_q <= IndexW'(idx_q);
      solution_q    <= signed'(a_rdata);
      last_q        <= (idx_q == last_idx);
    end
  end

  tps_ram #(
    .Width(QW),
    .Depth(MaxPoints)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(a_wdata),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  tps_ram #(
    .Width(2 * QW),
    .Depth(MaxPoints)
  ) u_pivot_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  tps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (prev_b_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_valid_o      = out_valid_q;
  assign point_index_o    = point_index_q;
  assign solution_value_o = solution_q;
  assign last_result_o    = last_q;

endmodule
